### sv/dma_controller_regs_irq_macros.svh
// Assertion macros for the DMA register front.
// Used by dma_controller_regs_irq; expects clk and rst_n in scope.
`ifndef DMA_CONTROLLER_REGS_IRQ_MACROS_SVH
`define DMA_CONTROLLER_REGS_IRQ_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/dcr_pkg.sv
// Shared types and constants of the DMA register front.
// No dependencies; used by dcr_ctrl, dcr_datapath and the top level.
package dcr_pkg;

    localparam int CHANNELS = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_COMMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2,
        OP_WALK  = 2'd3
    } opcode_t;

    // Register select within a channel or the global block
    localparam logic [1:0] REG_BASE    = 2'd0;
    localparam logic [1:0] REG_BLOCK   = 2'd1;
    localparam logic [1:0] REG_CTRL_A  = 2'd2;
    localparam logic [1:0] REG_CTRL_B  = 2'd3;
    localparam logic [1:0] GREG_CTRL   = 2'd0;
    localparam logic [1:0] GREG_IRQ    = 2'd1;

    // Channel numbers with special handling
    localparam logic [2:0] CH_LINKED = 3'd2;
    localparam logic [2:0] CH_HALF   = 3'd3;
    localparam logic [2:0] CH_NULL   = 3'd5;
    localparam logic [2:0] CH_FULL   = 3'd6;
    localparam logic [2:0] CH_GLOBAL = 3'd7;

    localparam logic [31:0] IRQ_CTRL_MASK = 32'h00ff803f;
    localparam logic [31:0] CTRL_MASK_CH6 = 32'h51000002;
    localparam logic [31:0] CTRL_MASK     = 32'h71770703;
    localparam logic [20:0] ADDR_MASK     = 21'h1FFFFC;
    localparam logic [31:0] LOW16_MASK    = 32'h0000FFFF;

    localparam int BIT_BUSY   = 24;
    localparam int BIT_LINKED = 10;
    localparam int BIT_GPU_EN = 11;

    typedef struct packed {
        logic load;
        logic calc;
        logic commit;
    } cmd_t;

endpackage

### sv/dcr_ctrl.sv
// Sequencer of the DMA register front: capture, compute, commit.
// Depends on dcr_pkg.
module dcr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output dcr_pkg::cmd_t cmd
);
    import dcr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/dcr_datapath.sv
// Register file, countdowns and result registers of the DMA register front.
// Depends on dcr_pkg; sequenced by dcr_ctrl through cmd_t.
module dcr_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  dcr_pkg::cmd_t cmd,
    input  logic [1:0]    opcode,
    input  logic [6:0]    reg_address,
    input  logic [31:0]   write_data,
    input  logic [23:0]   elapsed_clocks,
    input  logic [19:0]   walk_steps,
    output logic          strobe,
    output logic [31:0]   read_data,
    output logic          irq_out,
    output logic          start_valid,
    output logic [2:0]    start_channel,
    output logic [20:0]   start_address,
    output logic [31:0]   start_word_count,
    output logic          start_to_device,
    output logic          start_linked,
    output logic [6:0]    done_mask,
    output logic          gpu_write_active
);
    import dcr_pkg::*;

    // Captured transfer
    opcode_t     op_reg;
    logic [6:0]  addr_reg;
    logic [31:0] wd_reg;
    logic [23:0] elapsed_reg;
    logic [19:0] steps_reg;
    logic [31:0] prod_reg;

    // Architectural state
    logic [31:0] gc_reg, gc_next;
    logic [31:0] ic_reg, ic_next;
    logic [6:0]  is_reg, is_next;
    logic        irq_reg, irq_next;
    logic [23:0] base_reg [CHANNELS];
    logic [23:0] base_next [CHANNELS];
    logic [31:0] bc_reg [CHANNELS];
    logic [31:0] bc_next [CHANNELS];
    logic [31:0] cc_reg [CHANNELS];
    logic [31:0] cc_next [CHANNELS];
    logic [31:0] fd_reg [CHANNELS];
    logic [31:0] fd_next [CHANNELS];

    // Result registers
    logic        strobe_reg;
    logic [31:0] rd_reg, rd_next;
    logic        sv_reg, sv_next;
    logic [2:0]  sch_reg, sch_next;
    logic [20:0] sad_reg, sad_next;
    logic [31:0] swc_reg, swc_next;
    logic        sdev_reg, sdev_next;
    logic        slk_reg, slk_next;
    logic [6:0]  done_reg, done_next;

    logic [2:0]  ch;
    logic [1:0]  rsel;
    logic [4:0]  sh;
    logic        is_global;
    logic [31:0] v;
    logic [31:0] bc_sel;
    logic [31:0] cc_old;
    logic [31:0] cnt;
    logic        linked;
    logic [31:0] rval;
    logic [31:0] elapsed_ext;

    assign ch          = addr_reg[6:4];
    assign rsel        = addr_reg[3:2];
    assign sh          = {addr_reg[1:0], 3'b000};
    assign is_global   = (ch == CH_GLOBAL);
    assign v           = wd_reg << sh;
    assign elapsed_ext = {8'd0, elapsed_reg};
    assign bc_sel      = is_global ? 32'd0 : bc_reg[ch];
    assign cc_old      = is_global ? 32'd0 : cc_reg[ch];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= opcode_t'(opcode);
            addr_reg    <= reg_address;
            wd_reg      <= write_data;
            elapsed_reg <= elapsed_clocks;
            steps_reg   <= walk_steps;
        end
        if (cmd.calc)
        begin
            prod_reg <= {16'd0, bc_sel[31:16]} * {16'd0, bc_sel[15:0]};
        end
        if (cmd.commit)
        begin
            rd_reg   <= rd_next;
            sv_reg   <= sv_next;
            sch_reg  <= sch_next;
            sad_reg  <= sad_next;
            swc_reg  <= swc_next;
            sdev_reg <= sdev_next;
            slk_reg  <= slk_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            gc_reg     <= '0;
            ic_reg     <= '0;
            is_reg     <= '0;
            irq_reg    <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                base_reg[i] <= '0;
                bc_reg[i]   <= '0;
                cc_reg[i]   <= '0;
                fd_reg[i]   <= '0;
            end
        end
        else
        begin
            strobe_reg <= cmd.commit;
            if (cmd.commit)
            begin
                gc_reg  <= gc_next;
                ic_reg  <= ic_next;
                is_reg  <= is_next;
                irq_reg <= irq_next;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    base_reg[i] <= base_next[i];
                    bc_reg[i]   <= bc_next[i];
                    cc_reg[i]   <= cc_next[i];
                    fd_reg[i]   <= fd_next[i];
                end
            end
        end
    end

    // Next state of one transfer
    always_comb
    begin
        gc_next   = gc_reg;
        ic_next   = ic_reg;
        is_next   = is_reg;
        base_next = base_reg;
        bc_next   = bc_reg;
        cc_next   = cc_reg;
        fd_next   = fd_reg;
        rd_next   = '0;
        sv_next   = 1'b0;
        sch_next  = '0;
        sad_next  = '0;
        swc_next  = '0;
        sdev_next = 1'b0;
        slk_next  = 1'b0;
        done_next = '0;
        rval      = '0;
        linked    = 1'b0;
        cnt       = '0;

        unique case (op_reg)
            OP_WRITE:
            begin
                if (is_global)
                begin
                    if (rsel == GREG_CTRL)
                    begin
                        gc_next = v;
                    end
                    else if (rsel == GREG_IRQ)
                    begin
                        ic_next = v & IRQ_CTRL_MASK;
                        is_next = is_reg & ~v[30:24];
                    end
                end
                else
                begin
                    unique case (rsel) inside
                        REG_BASE:  base_next[ch] = v[23:0];
                        REG_BLOCK: bc_next[ch] = v;
                        REG_CTRL_A, REG_CTRL_B:
                        begin
                            cc_next[ch] = v & ((ch == CH_FULL) ? CTRL_MASK_CH6 : CTRL_MASK);
                            if (cc_old[BIT_BUSY] && !v[BIT_BUSY])
                            begin
                                fd_next[ch] = '0;
                            end
                            if (!cc_old[BIT_BUSY] && v[BIT_BUSY])
                            begin
                                linked = (ch == CH_LINKED) && v[BIT_LINKED];
                                if (ch == CH_FULL)
                                    cnt = bc_sel;
                                else if (ch == CH_HALF)
                                    cnt = bc_sel & LOW16_MASK;
                                else if (linked)
                                    cnt = '0;
                                else
                                    cnt = prod_reg;
                                if (linked)
                                    fd_next[ch] = '0;
                                else if (ch == CH_NULL || cnt == '0)
                                    fd_next[ch] = 32'd1;
                                else
                                    fd_next[ch] = cnt;
                                sv_next   = 1'b1;
                                sch_next  = ch;
                                sad_next  = base_reg[ch][20:0] & ADDR_MASK;
                                swc_next  = cnt;
                                sdev_next = cc_next[ch][0];
                                slk_next  = linked;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_READ:
            begin
                if (is_global)
                begin
                    if (rsel == GREG_CTRL)
                        rval = gc_reg;
                    else if (rsel == GREG_IRQ)
                        rval = ic_reg | {irq_reg, is_reg, 24'd0};
                end
                else
                begin
                    unique case (rsel) inside
                        REG_BASE:               rval = {8'd0, base_reg[ch]};
                        REG_BLOCK:              rval = bc_reg[ch];
                        REG_CTRL_A, REG_CTRL_B: rval = cc_reg[ch];
                        default:                rval = '0;
                    endcase
                end
                rd_next = rval >> sh;
            end
            OP_TICK:
            begin
                // All countdowns advance together
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (fd_reg[c] != '0)
                    begin
                        if (fd_reg[c] <= elapsed_ext)
                        begin
                            fd_next[c]           = '0;
                            cc_next[c][BIT_BUSY] = 1'b0;
                            if (ic_reg[16 + c])
                                is_next[c] = 1'b1;
                            done_next[c] = 1'b1;
                        end
                        else
                        begin
                            fd_next[c] = fd_reg[c] - elapsed_ext;
                        end
                    end
                end
            end
            OP_WALK:
            begin
                // Walk report only arms a linked transfer still waiting on it
                if (cc_reg[CH_LINKED][BIT_BUSY] && cc_reg[CH_LINKED][BIT_LINKED]
                    && fd_reg[CH_LINKED] == '0)
                begin
                    fd_next[CH_LINKED] = (steps_reg == '0) ? 32'd1 : {12'd0, steps_reg};
                end
            end
            default: ;
        endcase

        irq_next = (((is_next & ic_next[22:16]) != '0) && ic_next[23]) || ic_next[15];
    end

    assign strobe           = strobe_reg;
    assign read_data        = rd_reg;
    assign irq_out          = irq_reg;
    assign start_valid      = sv_reg;
    assign start_channel    = sch_reg;
    assign start_address    = sad_reg;
    assign start_word_count = swc_reg;
    assign start_to_device  = sdev_reg;
    assign start_linked     = slk_reg;
    assign done_mask        = done_reg;
    assign gpu_write_active = gc_reg[BIT_GPU_EN] & cc_reg[CH_LINKED][BIT_BUSY]
                              & cc_reg[CH_LINKED][0];

endmodule

### sv/dma_controller_regs_irq.sv
// Top level of the DMA register front: sequencer plus datapath.
// Depends on dcr_pkg, dcr_ctrl, dcr_datapath and the assertion macro header.
//
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------------------
//  command   | start / busy           | opcode, reg_address, write_data,
//            |                        | elapsed_clocks, walk_steps
//  result    | strobe (one cycle)     | read_data, irq_out, start_*, done_mask,
//            |                        | gpu_write_active
//
// Each transfer runs through capture, block-control multiply and commit, in that order.
// The strobe follows in the cycle after commit; busy is already low then.
// The 16x16 word-count product, registered before commit, sets the depth.
// Reset clears the register file, countdowns and interrupt state; no clearing pass is needed.
// Results cannot be stalled; each is presented exactly once.
`include "dma_controller_regs_irq_macros.svh"

module dma_controller_regs_irq (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [6:0]  reg_address,
    input  logic [31:0] write_data,
    input  logic [23:0] elapsed_clocks,
    input  logic [19:0] walk_steps,
    output logic        strobe,
    output logic [31:0] read_data,
    output logic        irq_out,
    output logic        start_valid,
    output logic [2:0]  start_channel,
    output logic [20:0] start_address,
    output logic [31:0] start_word_count,
    output logic        start_to_device,
    output logic        start_linked,
    output logic [6:0]  done_mask,
    output logic        gpu_write_active
);
    import dcr_pkg::*;

    cmd_t cmd;

    dcr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    dcr_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .opcode           (opcode),
        .reg_address      (reg_address),
        .write_data       (write_data),
        .elapsed_clocks   (elapsed_clocks),
        .walk_steps       (walk_steps),
        .strobe           (strobe),
        .read_data        (read_data),
        .irq_out          (irq_out),
        .start_valid      (start_valid),
        .start_channel    (start_channel),
        .start_address    (start_address),
        .start_word_count (start_word_count),
        .start_to_device  (start_to_device),
        .start_linked     (start_linked),
        .done_mask        (done_mask),
        .gpu_write_active (gpu_write_active)
    );

    `DCR_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !strobe, "accept not held busy")
    `DCR_ASSERT_SAME(a_strobe_idle, strobe, !busy, "result strobe while still busy")
    `DCR_ASSERT_SAME(a_strobe_after_work, strobe, $past(busy && !strobe), "strobe without work")
    `DCR_ASSERT_NEXT(a_commit_strobe, cmd.commit, strobe, "commit not followed by strobe")

endmodule

### verif/dcr_checker.sv
// Scoreboard for the DMA register front: tracks registers, countdowns and interrupt
// state from accepted commands, and compares every strobed result against its prediction.
// Depends on dcr_pkg.
`timescale 1ns / 1ps

module dcr_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  opcode,
    input  logic [6:0]  reg_address,
    input  logic [31:0] write_data,
    input  logic [23:0] elapsed_clocks,
    input  logic [19:0] walk_steps,
    input  logic        strobe,
    input  logic [31:0] read_data,
    input  logic        irq_out,
    input  logic        start_valid,
    input  logic [2:0]  start_channel,
    input  logic [20:0] start_address,
    input  logic [31:0] start_word_count,
    input  logic        start_to_device,
    input  logic        start_linked,
    input  logic [6:0]  done_mask,
    input  logic        gpu_write_active,
    output int          mismatches,
    output int          pending,
    output int          checked,
    output int          transfers,
    output int          completions
);
    import dcr_pkg::*;

    typedef struct packed {
        logic [31:0] rdata;
        logic        irq;
        logic        valid;
        logic [2:0]  channel;
        logic [20:0] address;
        logic [31:0] words;
        logic        to_device;
        logic        linked;
        logic [6:0]  done;
        logic        gpu;
    } dma_result_t;

    // Model of the register file and countdowns
    logic [31:0] glob_ctrl;
    logic [31:0] irq_ctrl;
    logic [6:0]  irq_stat;
    logic        irq_lvl;
    logic [23:0] base_q  [CHANNELS];
    logic [31:0] blk_q   [CHANNELS];
    logic [31:0] chctl_q [CHANNELS];
    logic [31:0] delay_q [CHANNELS];

    dma_result_t expected_results[$];
    dma_result_t want;
    dma_result_t got;
    int          n_err;
    int          n_checked;
    int          n_starts;
    int          n_done;

    task automatic apply_command(input logic [1:0] op, input logic [6:0] addr,
                                 input logic [31:0] wd, input logic [23:0] el,
                                 input logic [19:0] ws, output dma_result_t r);
        logic [2:0]  ch;
        logic [1:0]  rsel;
        logic [4:0]  sh;
        logic [31:0] v;
        logic [31:0] prev;
        logic [31:0] regval;
        logic [31:0] cnt;
        logic        linked;
        ch   = addr[6:4];
        rsel = addr[3:2];
        sh   = {addr[1:0], 3'b000};
        r    = '0;
        case (op)
            OP_WRITE:
            begin
                v = wd << sh;
                if (ch == CH_GLOBAL)
                begin
                    if (rsel == GREG_CTRL)
                        glob_ctrl = v;
                    else if (rsel == GREG_IRQ)
                    begin
                        irq_ctrl = v & IRQ_CTRL_MASK;
                        irq_stat = irq_stat & ~v[30:24];
                    end
                end
                else if (rsel == REG_BASE)
                    base_q[ch] = v[23:0];
                else if (rsel == REG_BLOCK)
                    blk_q[ch] = v;
                else
                begin
                    prev = chctl_q[ch];
                    chctl_q[ch] = v & ((ch == CH_FULL) ? CTRL_MASK_CH6 : CTRL_MASK);
                    // clearing busy on a running channel aborts it silently
                    if (prev[BIT_BUSY] && !v[BIT_BUSY])
                        delay_q[ch] = '0;
                    if (!prev[BIT_BUSY] && v[BIT_BUSY])
                    begin
                        linked = (ch == CH_LINKED) && v[BIT_LINKED];
                        if (ch == CH_FULL)
                            cnt = blk_q[ch];
                        else if (ch == CH_HALF)
                            cnt = blk_q[ch] & LOW16_MASK;
                        else if (linked)
                            cnt = '0;
                        else
                            cnt = 32'(blk_q[ch][31:16]) * 32'(blk_q[ch][15:0]);
                        // linked mode waits for the walk report before counting down
                        if (linked)
                            delay_q[ch] = '0;
                        else if (ch == CH_NULL || cnt == '0)
                            delay_q[ch] = 32'd1;
                        else
                            delay_q[ch] = cnt;
                        r.valid     = 1'b1;
                        r.channel   = ch;
                        r.address   = base_q[ch][20:0] & ADDR_MASK;
                        r.words     = cnt;
                        r.to_device = chctl_q[ch][0];
                        r.linked    = linked;
                    end
                end
            end
            OP_READ:
            begin
                regval = '0;
                if (ch == CH_GLOBAL)
                begin
                    if (rsel == GREG_CTRL)
                        regval = glob_ctrl;
                    else if (rsel == GREG_IRQ)
                        regval = irq_ctrl | {irq_lvl, irq_stat, 24'h000000};
                end
                else if (rsel == REG_BASE)
                    regval = {8'h00, base_q[ch]};
                else if (rsel == REG_BLOCK)
                    regval = blk_q[ch];
                else
                    regval = chctl_q[ch];
                r.rdata = regval >> sh;
            end
            OP_TICK:
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (delay_q[c] != '0)
                    begin
                        if (delay_q[c] <= {8'h00, el})
                        begin
                            delay_q[c] = '0;
                            chctl_q[c][BIT_BUSY] = 1'b0;
                            if (irq_ctrl[16 + c])
                                irq_stat[c] = 1'b1;
                            r.done[c] = 1'b1;
                        end
                        else
                            delay_q[c] = delay_q[c] - {8'h00, el};
                    end
                end
            end
            default:
            begin
                if (chctl_q[CH_LINKED][BIT_BUSY] && chctl_q[CH_LINKED][BIT_LINKED]
                    && delay_q[CH_LINKED] == '0)
                    delay_q[CH_LINKED] = (ws != '0) ? {12'h000, ws} : 32'd1;
            end
        endcase
        irq_lvl = (((irq_stat & irq_ctrl[22:16]) != '0) && irq_ctrl[23]) || irq_ctrl[15];
        r.irq = irq_lvl;
        r.gpu = glob_ctrl[BIT_GPU_EN] && chctl_q[CH_LINKED][BIT_BUSY] && chctl_q[CH_LINKED][0];
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            n_err++;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            glob_ctrl = '0;
            irq_ctrl  = '0;
            irq_stat  = '0;
            irq_lvl   = 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                base_q[c]  = '0;
                blk_q[c]   = '0;
                chctl_q[c] = '0;
                delay_q[c] = '0;
            end
            expected_results.delete();
            n_err     = 0;
            n_checked = 0;
            n_starts  = 0;
            n_done    = 0;
        end
        else
        begin
            // result of an earlier transfer is retired before the new one is predicted
            if (strobe)
            begin
                got = '{read_data, irq_out, start_valid, start_channel, start_address,
                        start_word_count, start_to_device, start_linked, done_mask,
                        gpu_write_active};
                if (expected_results.size() == 0)
                begin
                    if (n_err < 40)
                        $error("result strobe with no command outstanding");
                    n_err++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_data", want.rdata, got.rdata);
                    check_field("irq_out", 32'(want.irq), 32'(got.irq));
                    check_field("start_valid", 32'(want.valid), 32'(got.valid));
                    check_field("start_channel", 32'(want.channel), 32'(got.channel));
                    check_field("start_address", 32'(want.address), 32'(got.address));
                    check_field("start_word_count", want.words, got.words);
                    check_field("start_to_device", 32'(want.to_device), 32'(got.to_device));
                    check_field("start_linked", 32'(want.linked), 32'(got.linked));
                    check_field("done_mask", 32'(want.done), 32'(got.done));
                    check_field("gpu_write_active", 32'(want.gpu), 32'(got.gpu));
                    n_checked++;
                end
            end
            if (start && !busy)
            begin
                apply_command(opcode, reg_address, write_data, elapsed_clocks, walk_steps,
                              want);
                expected_results.push_back(want);
                n_starts += want.valid;
                n_done   += $countones(want.done);
            end
        end
        mismatches  <= n_err;
        pending     <= expected_results.size();
        checked     <= n_checked;
        transfers   <= n_starts;
        completions <= n_done;
    end

endmodule

### verif/dma_controller_regs_irq_tb.sv
// Testbench top for the DMA register front: clock, reset, command stimulus and verdict.
// Depends on dcr_pkg, dma_controller_regs_irq and dcr_checker.
`timescale 1ns / 1ps

module dma_controller_regs_irq_tb;
    import dcr_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  opcode = '0;
    logic [6:0]  reg_address = '0;
    logic [31:0] write_data = '0;
    logic [23:0] elapsed_clocks = '0;
    logic [19:0] walk_steps = '0;
    logic        strobe;
    logic [31:0] read_data;
    logic        irq_out;
    logic        start_valid;
    logic [2:0]  start_channel;
    logic [20:0] start_address;
    logic [31:0] start_word_count;
    logic        start_to_device;
    logic        start_linked;
    logic [6:0]  done_mask;
    logic        gpu_write_active;

    int mismatches;
    int pending;
    int checked;
    int transfers;
    int completions;

    int n_cmds;
    int n_writes;
    int n_reads;
    int n_ticks;
    int n_walks;
    int burst_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dma_controller_regs_irq u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .reg_address      (reg_address),
        .write_data       (write_data),
        .elapsed_clocks   (elapsed_clocks),
        .walk_steps       (walk_steps),
        .strobe           (strobe),
        .read_data        (read_data),
        .irq_out          (irq_out),
        .start_valid      (start_valid),
        .start_channel    (start_channel),
        .start_address    (start_address),
        .start_word_count (start_word_count),
        .start_to_device  (start_to_device),
        .start_linked     (start_linked),
        .done_mask        (done_mask),
        .gpu_write_active (gpu_write_active)
    );

    dcr_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .reg_address      (reg_address),
        .write_data       (write_data),
        .elapsed_clocks   (elapsed_clocks),
        .walk_steps       (walk_steps),
        .strobe           (strobe),
        .read_data        (read_data),
        .irq_out          (irq_out),
        .start_valid      (start_valid),
        .start_channel    (start_channel),
        .start_address    (start_address),
        .start_word_count (start_word_count),
        .start_to_device  (start_to_device),
        .start_linked     (start_linked),
        .done_mask        (done_mask),
        .gpu_write_active (gpu_write_active),
        .mismatches       (mismatches),
        .pending          (pending),
        .checked          (checked),
        .transfers        (transfers),
        .completions      (completions)
    );

    function automatic logic [6:0] reg_at(input logic [2:0] ch, input logic [1:0] rsel);
        return {ch, rsel, 2'b00};
    endfunction

    // Present one command and hold it until the block takes it; bursts and gaps follow.
    task automatic do_cmd(input opcode_t op, input logic [6:0] addr, input logic [31:0] wd,
                          input logic [23:0] el, input logic [19:0] ws);
        int gap;
        start          <= 1'b1;
        opcode         <= op;
        reg_address    <= addr;
        write_data     <= wd;
        elapsed_clocks <= el;
        walk_steps     <= ws;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n_cmds++;
        case (op)
            OP_WRITE: n_writes++;
            OP_READ:  n_reads++;
            OP_TICK:  n_ticks++;
            default:  n_walks++;
        endcase
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic bus_write(input logic [6:0] addr, input logic [31:0] wd);
        do_cmd(OP_WRITE, addr, wd, 24'($urandom), 20'($urandom));
    endtask

    task automatic bus_read(input logic [6:0] addr);
        do_cmd(OP_READ, addr, $urandom, 24'($urandom), 20'($urandom));
    endtask

    task automatic tick(input logic [23:0] el);
        do_cmd(OP_TICK, 7'($urandom), $urandom, el, 20'($urandom));
    endtask

    task automatic walk_done(input logic [19:0] ws);
        do_cmd(OP_WALK, 7'($urandom), $urandom, 24'($urandom), ws);
    endtask

    initial
    begin
        int          sel;
        int          random_end;
        int          guard;
        logic [2:0]  ch;
        logic [31:0] bc;
        logic [31:0] ctl;
        logic [23:0] el;

        burst_left = 0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: register extremes, lanes, each channel's count rule, irq paths
        bus_read(reg_at(CH_GLOBAL, GREG_CTRL));
        bus_write(reg_at(CH_GLOBAL, GREG_CTRL), 32'hFFFF_FFFF);
        bus_write(reg_at(CH_GLOBAL, GREG_IRQ), 32'hFFFF_FFFF);   // bit 15 forces the line
        bus_read(reg_at(CH_GLOBAL, GREG_IRQ));
        bus_write(reg_at(CH_GLOBAL, GREG_IRQ), 32'h00FF_0000);
        bus_write(reg_at(CH_GLOBAL, 2'd2), 32'hFFFF_FFFF);
        bus_read(reg_at(CH_GLOBAL, 2'd3) | 7'd3);
        bus_write(reg_at(3'd0, REG_BASE), 32'hFFFF_FFFF);
        bus_read(reg_at(3'd0, REG_BASE) | 7'd1);
        bus_write(reg_at(3'd0, REG_BLOCK), 32'h0002_0003);
        bus_write(reg_at(3'd0, REG_CTRL_A), 32'h0100_0001);
        tick(24'd0);
        tick(24'd5);
        tick(24'd1);
        bus_write(reg_at(CH_LINKED, REG_CTRL_B), 32'h0100_0401);
        walk_done(20'd0);
        walk_done(20'hFFFFF);                                   // ignored: delay already set
        tick(24'hFF_FFFF);
        bus_write(reg_at(CH_NULL, REG_BLOCK), 32'hFFFF_FFFF);
        bus_write(reg_at(CH_NULL, REG_CTRL_B), 32'h0100_0000);
        bus_write(reg_at(CH_FULL, REG_CTRL_A), 32'hFFFF_FFFF);
        bus_write(reg_at(CH_HALF, REG_BLOCK) | 7'd3, 32'h0000_00AB);
        bus_write(reg_at(CH_HALF, REG_CTRL_B), 32'h0100_0000);
        bus_write(reg_at(3'd1, REG_BLOCK), 32'h0010_0010);
        bus_write(reg_at(3'd1, REG_CTRL_A), 32'h0100_0000);
        bus_write(reg_at(3'd1, REG_CTRL_A), 32'h0000_0000);     // aborted, no completion
        tick(24'hFF_FFFF);
        bus_read(reg_at(CH_GLOBAL, GREG_IRQ) | 7'd2);
        bus_write(reg_at(CH_GLOBAL, GREG_IRQ), 32'h7FFF_0000);

        random_end = n_cmds + 400;
        while (n_cmds < random_end)
        begin
            sel = $urandom_range(0, 99);
            ch  = 3'($urandom_range(0, CHANNELS - 1));
            if (sel < 50)
            begin
                // typical channel setup and kick-off, then let time pass
                bus_write(reg_at(ch, REG_BASE), $urandom);
                if ($urandom_range(0, 11) == 0)
                    bc = $urandom;
                else
                    bc = {(($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 3))),
                          (($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 20)))};
                bus_write(reg_at(ch, REG_BLOCK), bc);
                ctl = $urandom;
                ctl[BIT_BUSY] = 1'b1;
                if (ch == CH_LINKED)
                    ctl[BIT_LINKED] = ($urandom_range(0, 2) != 0);
                bus_write(reg_at(ch, ($urandom_range(0, 1) != 0) ? REG_CTRL_B : REG_CTRL_A), ctl);
                if (ch == CH_LINKED && ctl[BIT_LINKED])
                    walk_done(($urandom_range(0, 7) == 0) ? 20'($urandom)
                                                          : 20'($urandom_range(0, 30)));
                repeat ($urandom_range(0, 3))
                begin
                    el = ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 40));
                    tick(el);
                end
                if ($urandom_range(0, 2) == 0)
                    bus_read(reg_at(ch, REG_CTRL_A) | 7'($urandom_range(0, 7)));
            end
            else if (sel < 65)
            begin
                el = ($urandom_range(0, 5) == 0) ? 24'($urandom) : 24'($urandom_range(0, 64));
                tick(el);
            end
            else if (sel < 75)
            begin
                if ($urandom_range(0, 3) == 0)
                    bus_write(reg_at(CH_GLOBAL, GREG_IRQ), $urandom);
                else if ($urandom_range(0, 2) == 0)
                    bus_write(reg_at(CH_GLOBAL, GREG_CTRL), $urandom);
                else
                    bus_write(reg_at(CH_GLOBAL, GREG_IRQ),
                              ($urandom & 32'h7FFF_7FFF) | 32'h0080_0000);
                bus_read(reg_at(CH_GLOBAL, GREG_IRQ));
            end
            else if (sel < 85)
            begin
                // abort a channel that may be running
                ctl = $urandom;
                ctl[BIT_BUSY] = 1'b0;
                bus_write(reg_at(ch, REG_CTRL_A), ctl);
            end
            else if (sel < 92)
                bus_read(7'($urandom_range(0, 127)));
            else
                do_cmd(opcode_t'($urandom_range(0, 3)), 7'($urandom_range(0, 127)), $urandom,
                       24'($urandom), 20'($urandom));
        end

        start <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8)
            @(posedge clk);

        if (pending != 0)
            $error("%0d results never arrived", pending);
        $display("Sent %0d commands: %0d writes, %0d reads, %0d ticks, %0d walk reports.",
                 n_cmds, n_writes, n_reads, n_ticks, n_walks);
        $display("Checked %0d results covering %0d transfer starts and %0d completions.",
                 checked, transfers, completions);
        if (mismatches == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/dcr_pkg.sv
sv/dcr_ctrl.sv
sv/dcr_datapath.sv
sv/dma_controller_regs_irq.sv
verif/dcr_checker.sv
verif/dma_controller_regs_irq_tb.sv
